### rtl/wts_pkg.sv
// Shared types and constants for the waypoint tracking servo step.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package wts_pkg;

    localparam int MAX_POINTS = 128;
    localparam int COORD_BITS = 10;

    localparam int CW      = COORD_BITS;
    localparam int CORNER_W = 20;
    localparam int SEG_W   = 6;
    localparam int IDX_W   = 7;
    localparam int PLEN_W  = IDX_W + 1;
    localparam int SEG_MAX = MAX_POINTS / 4;
    localparam int POS_W   = $clog2(SEG_MAX);
    localparam int PROD_W  = CW + POS_W;
    localparam int CNT_W   = $clog2(PROD_W + 1);
    localparam int ERR_W   = CW + 2;
    localparam int SQ_W    = 2 * CW;
    localparam int D2_W    = SQ_W + 1;
    localparam int SERVO_W = 12;
    localparam int RATE_W  = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 3'd4;

    localparam logic [PLEN_W-1:0]  PLEN_MAX   = PLEN_W'(MAX_POINTS);
    localparam logic [ERR_W-1:0]   STEP_ERR   = ERR_W'(15);
    localparam logic [D2_W-1:0]    NEAR_SQ    = D2_W'(500);
    localparam logic [SERVO_W-1:0] PAN_MIN    = 12'd2700;
    localparam logic [SERVO_W-1:0] PAN_MAX    = 12'd3400;
    localparam logic [SERVO_W-1:0] TILT_MIN   = 12'd3100;
    localparam logic [SERVO_W-1:0] TILT_MAX   = 12'd3600;
    localparam logic [SERVO_W-1:0] PAN_RESET  = 12'd2970;
    localparam logic [SERVO_W-1:0] TILT_RESET = 12'd3290;
    localparam logic [RATE_W-1:0]  RATE_HI    = 10'd1000;
    localparam logic [RATE_W-1:0]  RATE_LO    = 10'd350;
    localparam logic [IDX_W-1:0]   BAND1_LO   = 7'd1;
    localparam logic [IDX_W-1:0]   BAND1_HI   = 7'd25;
    localparam logic [IDX_W-1:0]   BAND2_LO   = 7'd51;
    localparam logic [IDX_W-1:0]   BAND2_HI   = 7'd75;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIDE,
        S_MUL,
        S_DIV,
        S_ERR,
        S_SQ,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

### rtl/wts_spot_if.sv
// Input channel of the servo step: one measured spot position per request.
// Depends on wts_pkg for the coordinate width.
`default_nettype none
interface wts_spot_if
    import wts_pkg::*;
();
    logic          valid;
    logic          ready;
    logic [CW-1:0] spot_x;
    logic [CW-1:0] spot_y;

    modport source (output valid, output spot_x, output spot_y, input ready);
    modport sink   (input valid, input spot_x, input spot_y, output ready);
endinterface
`default_nettype wire

### rtl/wts_cmd_if.sv
// Output channel of the servo step: one servo command per request.
// Depends on wts_pkg for the field widths.
`default_nettype none
interface wts_cmd_if
    import wts_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               active;
    logic [SERVO_W-1:0] pan_position;
    logic [SERVO_W-1:0] tilt_position;
    logic [RATE_W-1:0]  pan_rate;
    logic [RATE_W-1:0]  tilt_rate;
    logic [IDX_W-1:0]   waypoint;
    logic               reached;

    modport source (output valid, output active, output pan_position, output tilt_position,
                    output pan_rate, output tilt_rate, output waypoint, output reached,
                    input ready);
    modport sink   (input valid, input active, input pan_position, input tilt_position,
                    input pan_rate, input tilt_rate, input waypoint, input reached,
                    output ready);
endinterface
`default_nettype wire

### rtl/waypoint_tracking_servo_step.sv
// Waypoint tracking servo step. A request on a valid path passes the side search, multiply,
// divide, error, square and finish states; on an invalid path it goes straight to finish.
// Finish waits until the output is free; a new request is taken only when idle again.
// The time is set by the bit-serial multiply and the restoring divide, one bit a cycle each.
// Synchronous active-low reset clears configuration and waypoint index and homes the servos.
// Depends on wts_pkg, wts_spot_if and wts_cmd_if.
`default_nettype none
module waypoint_tracking_servo_step
    import wts_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CORNER_W-1:0]   i_cfg_data,
    wts_spot_if.sink                   i_spot,
    wts_cmd_if.source                  o_cmd
);

    t_state r_state, n_state;

    logic [CORNER_W-1:0] r_corner_a, r_corner_b, r_corner_c, r_corner_d;
    logic [SEG_W-1:0]    r_seg;
    logic [IDX_W-1:0]    r_idx;
    logic [SERVO_W-1:0]  r_pan, r_tilt;

    logic                r_ok;
    logic [IDX_W-1:0]    r_rem;
    logic [1:0]          r_side;
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_cnt;
    logic [CW-1:0]       r_spot [2];
    logic [CW-1:0]       r_base [2];
    logic [CW-1:0]       r_mag  [2];
    logic                r_neg  [2];
    logic [PROD_W-1:0]   r_acc  [2];
    logic [SEG_W-1:0]    r_rdr  [2];
    logic [ERR_W-1:0]    r_err  [2];
    logic [SQ_W-1:0]     r_sq   [2];

    logic                r_out_valid;
    logic                r_o_active, r_o_reached;
    logic [SERVO_W-1:0]  r_o_pan, r_o_tilt;
    logic [RATE_W-1:0]   r_o_pan_rate, r_o_tilt_rate;
    logic [IDX_W-1:0]    r_o_waypoint;

    logic [PLEN_W-1:0]   path_len;
    logic                path_ok;
    logic                side_done;
    logic                in_fire, fin_fire, out_free;
    logic [CORNER_W-1:0] sel_a, sel_b;
    logic [CW-1:0]       coord_a [2];
    logic [CW-1:0]       coord_b [2];
    logic [CW:0]         diff    [2];
    logic [IDX_W-1:0]    seg_ext;
    logic [ERR_W-1:0]    err_next [2];
    logic [CW-1:0]       err_mag  [2];
    logic                step_up  [2];
    logic                step_dn  [2];
    logic [D2_W-1:0]     d2;
    logic                reached;
    logic                rate_band;
    logic [PLEN_W-1:0]   idx_inc;
    logic [IDX_W-1:0]    idx_next;
    logic [SERVO_W-1:0]  pan_next, tilt_next;

    assign path_len = {1'b0, r_seg, 1'b0} << 1;
    assign path_ok  = (r_seg != '0) && (path_len <= PLEN_MAX)
                      && ({1'b0, r_idx} < path_len);
    assign seg_ext  = IDX_W'(r_seg);
    assign side_done = (r_rem < seg_ext) || (r_side == 2'd3);

    assign out_free = !r_out_valid || o_cmd.ready;
    assign in_fire  = i_spot.valid && (r_state == S_IDLE);
    assign fin_fire = (r_state == S_FIN) && out_free;

    assign i_spot.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_spot.valid) n_state = path_ok ? S_SIDE : S_FIN;
            S_SIDE: if (side_done) n_state = S_MUL;
            S_MUL:  if (r_cnt == CNT_W'(POS_W - 1)) n_state = S_DIV;
            S_DIV:  if (r_cnt == CNT_W'(PROD_W - 1)) n_state = S_ERR;
            S_ERR:  n_state = S_SQ;
            S_SQ:   n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Corner pair of the current side: start corner and the one after it.
    always_comb begin
        case (r_side)
            2'd0: begin sel_a = r_corner_a; sel_b = r_corner_b; end
            2'd1: begin sel_a = r_corner_b; sel_b = r_corner_c; end
            2'd2: begin sel_a = r_corner_c; sel_b = r_corner_d; end
            default: begin sel_a = r_corner_d; sel_b = r_corner_a; end
        endcase
    end

    always_comb begin
        logic [CW:0]     q;
        logic [CW:0]     offm;
        logic [ERR_W-1:0] off;
        logic [ERR_W-1:0] tgt;
        coord_a[0] = sel_a[CW-1:0];
        coord_a[1] = sel_a[2*CW-1:CW];
        coord_b[0] = sel_b[CW-1:0];
        coord_b[1] = sel_b[2*CW-1:CW];
        for (int l = 0; l < 2; l++) begin
            diff[l] = {1'b0, coord_b[l]} - {1'b0, coord_a[l]};
            // Floor toward minus infinity: a negative quotient with a remainder rounds away.
            q    = r_acc[l][CW:0];
            offm = q + (CW+1)'(r_neg[l] && (r_rdr[l] != '0));
            off  = r_neg[l] ? (ERR_W'(0) - {1'b0, offm}) : {1'b0, offm};
            tgt  = {2'b00, r_base[l]} + off;
            err_next[l] = tgt - {2'b00, r_spot[l]};
            err_mag[l]  = r_err[l][ERR_W-1] ? CW'(ERR_W'(0) - r_err[l]) : CW'(r_err[l]);
            step_up[l]  = !r_err[l][ERR_W-1] && (r_err[l] >= STEP_ERR);
            step_dn[l]  = r_err[l][ERR_W-1] && ((ERR_W'(0) - r_err[l]) >= STEP_ERR);
        end
    end

    assign d2      = D2_W'(r_sq[0]) + D2_W'(r_sq[1]);
    assign reached = (d2 < NEAR_SQ);
    assign rate_band = ((r_idx >= BAND1_LO) && (r_idx <= BAND1_HI))
                       || ((r_idx >= BAND2_LO) && (r_idx <= BAND2_HI));
    assign idx_inc  = {1'b0, r_idx} + PLEN_W'(1);
    assign idx_next = (idx_inc == path_len) ? '0 : idx_inc[IDX_W-1:0];

    // Servos start in range and move by one, so the clamp is a bound check.
    always_comb begin
        pan_next = r_pan;
        if (step_up[0] && (r_pan < PAN_MAX)) pan_next = r_pan + SERVO_W'(1);
        if (step_dn[0] && (r_pan > PAN_MIN)) pan_next = r_pan - SERVO_W'(1);
        tilt_next = r_tilt;
        if (step_up[1] && (r_tilt < TILT_MAX)) tilt_next = r_tilt + SERVO_W'(1);
        if (step_dn[1] && (r_tilt > TILT_MIN)) tilt_next = r_tilt - SERVO_W'(1);
    end

    // Configuration and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_a  <= '0;
            r_corner_b  <= '0;
            r_corner_c  <= '0;
            r_corner_d  <= '0;
            r_seg       <= '0;
            r_idx       <= '0;
            r_pan       <= PAN_RESET;
            r_tilt      <= TILT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CORNER_A: r_corner_a <= i_cfg_data;
                    CFG_CORNER_B: r_corner_b <= i_cfg_data;
                    CFG_CORNER_C: r_corner_c <= i_cfg_data;
                    CFG_CORNER_D: r_corner_d <= i_cfg_data;
                    CFG_SEGMENTS: r_seg <= i_cfg_data[SEG_W-1:0];
                    default: ;
                endcase
            end
            if (fin_fire && r_ok) begin
                r_pan  <= pan_next;
                r_tilt <= tilt_next;
                if (reached) r_idx <= idx_next;
            end
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Serial datapath: side search, shift-add multiply, restoring divide, error and square; output registers.
    always_ff @(posedge i_clk) begin
        r_cnt <= (n_state != r_state) ? '0 : r_cnt + CNT_W'(1);
        if (in_fire) begin
            r_ok      <= path_ok;
            r_rem     <= r_idx;
            r_side    <= '0;
            r_spot[0] <= i_spot.spot_x;
            r_spot[1] <= i_spot.spot_y;
        end
        case (r_state)
            S_SIDE: begin
                if (!side_done) begin
                    r_rem  <= r_rem - seg_ext;
                    r_side <= r_side + 2'd1;
                end else begin
                    r_pos <= r_rem[POS_W-1:0];
                    for (int l = 0; l < 2; l++) begin
                        r_base[l] <= coord_a[l];
                        r_neg[l]  <= diff[l][CW];
                        r_mag[l]  <= diff[l][CW] ? CW'((CW+1)'(0) - diff[l]) : diff[l][CW-1:0];
                        r_acc[l]  <= '0;
                        r_rdr[l]  <= '0;
                    end
                end
            end
            S_MUL: begin
                r_pos <= r_pos << 1;
                for (int l = 0; l < 2; l++) begin
                    r_acc[l] <= {r_acc[l][PROD_W-2:0], 1'b0}
                                + (r_pos[POS_W-1] ? PROD_W'(r_mag[l]) : '0);
                end
            end
            S_DIV: begin
                for (int l = 0; l < 2; l++) begin
                    logic [SEG_W:0] t;
                    logic           ge;
                    t  = {r_rdr[l], r_acc[l][PROD_W-1]};
                    ge = (t >= {1'b0, r_seg});
                    r_rdr[l] <= ge ? SEG_W'(t - {1'b0, r_seg}) : t[SEG_W-1:0];
                    r_acc[l] <= {r_acc[l][PROD_W-2:0], ge};
                end
            end
            S_ERR: begin
                for (int l = 0; l < 2; l++) r_err[l] <= err_next[l];
            end
            S_SQ: begin
                for (int l = 0; l < 2; l++) r_sq[l] <= SQ_W'(err_mag[l]) * SQ_W'(err_mag[l]);
            end
            default: ;
        endcase
        if (fin_fire) begin
            r_o_active   <= r_ok;
            r_o_pan      <= r_ok ? pan_next : r_pan;
            r_o_tilt     <= r_ok ? tilt_next : r_tilt;
            r_o_reached  <= r_ok && reached;
            r_o_waypoint <= (r_ok && reached) ? idx_next : r_idx;
            if (!r_ok) begin
                r_o_pan_rate  <= '0;
                r_o_tilt_rate <= '0;
            end else begin
                r_o_pan_rate  <= rate_band ? RATE_HI : RATE_LO;
                r_o_tilt_rate <= rate_band ? RATE_LO : RATE_HI;
            end
        end
    end

    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.active        = r_o_active;
    assign o_cmd.pan_position  = r_o_pan;
    assign o_cmd.tilt_position = r_o_tilt;
    assign o_cmd.pan_rate      = r_o_pan_rate;
    assign o_cmd.tilt_rate     = r_o_tilt_rate;
    assign o_cmd.waypoint      = r_o_waypoint;
    assign o_cmd.reached       = r_o_reached;

endmodule
`default_nettype wire

### verif/tb_waypoint_tracking_servo_step.sv
// Self-checking testbench for waypoint_tracking_servo_step: spot requests with random
// gaps on both channels, every result compared against an in-bench path/servo predictor.
// Depends on wts_pkg, wts_spot_if, wts_cmd_if and the block itself.
`default_nettype none
module tb_waypoint_tracking_servo_step;
    import wts_pkg::*;

    localparam int STALL_LIMIT = 3000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } t_spot_pos;

    typedef struct packed {
        logic               active;
        logic [SERVO_W-1:0] pan;
        logic [SERVO_W-1:0] tilt;
        logic [RATE_W-1:0]  pan_rate;
        logic [RATE_W-1:0]  tilt_rate;
        logic [IDX_W-1:0]   waypoint;
        logic               reached;
    } t_servo_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_CORNER_A;
    logic [CORNER_W-1:0]  cfg_data = '0;
    logic                 drv_valid = 1'b0;
    t_spot_pos            drv_spot = '0;
    logic                 mon_ready = 1'b0;

    // Predictor state, mirrors the block's registers.
    logic [CORNER_W-1:0]  path_corner [4] = '{default: '0};
    logic [SEG_W-1:0]     path_segs = '0;
    logic [IDX_W-1:0]     track_idx = '0;
    logic [SERVO_W-1:0]   pan_pos = PAN_RESET;
    logic [SERVO_W-1:0]   tilt_pos = TILT_RESET;

    t_spot_pos            pending_spots [$];
    t_servo_cmd           expected_cmds [$];
    t_servo_cmd           oldest_cmd;
    int                   n_queued = 0;
    int                   n_taken = 0;
    int                   n_fail = 0;
    int                   spot_gap = 0;
    int                   cmd_gap = 0;
    int                   quiet = 0;
    bit                   no_gaps = 1'b0;

    wts_spot_if spot_bus ();
    wts_cmd_if  cmd_bus ();

    assign spot_bus.valid  = drv_valid;
    assign spot_bus.spot_x = drv_spot.x;
    assign spot_bus.spot_y = drv_spot.y;
    assign cmd_bus.ready   = mon_ready;

    waypoint_tracking_servo_step uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_spot    (spot_bus),
        .o_cmd     (cmd_bus)
    );

    always #5 i_clk = ~i_clk;

    function automatic int floor_div(int num, int den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic int step_of(int err);
        if (err >= int'(STEP_ERR)) return 1;
        if (err <= -int'(STEP_ERR)) return -1;
        return 0;
    endfunction

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Interpolated waypoint for the present index; 0 when the path is not usable.
    function automatic bit track_target(output int tx, output int ty);
        int seg, plen, side, pos, ax, ay, bx, by;
        seg  = int'(path_segs);
        plen = 4 * seg;
        tx = 0;
        ty = 0;
        if (plen == 0 || plen > MAX_POINTS || int'(track_idx) >= plen) return 1'b0;
        side = (int'(track_idx) / seg) % 4;
        pos  = int'(track_idx) % seg;
        ax = int'(path_corner[side][CW-1:0]);
        ay = int'(path_corner[side][2*CW-1:CW]);
        bx = int'(path_corner[(side + 1) % 4][CW-1:0]);
        by = int'(path_corner[(side + 1) % 4][2*CW-1:CW]);
        tx = ax + floor_div(pos * (bx - ax), seg);
        ty = ay + floor_div(pos * (by - ay), seg);
        return 1'b1;
    endfunction

    function automatic t_servo_cmd servo_step(t_spot_pos s);
        t_servo_cmd r;
        int tx, ty, ex, ey;
        bit fast_pan;
        r.active    = 1'b0;
        r.pan       = pan_pos;
        r.tilt      = tilt_pos;
        r.pan_rate  = '0;
        r.tilt_rate = '0;
        r.waypoint  = track_idx;
        r.reached   = 1'b0;
        if (!track_target(tx, ty)) return r;
        ex = tx - int'(s.x);
        ey = ty - int'(s.y);
        fast_pan = (track_idx >= BAND1_LO && track_idx <= BAND1_HI) ||
                   (track_idx >= BAND2_LO && track_idx <= BAND2_HI);
        r.pan_rate  = fast_pan ? RATE_HI : RATE_LO;
        r.tilt_rate = fast_pan ? RATE_LO : RATE_HI;
        pan_pos  = SERVO_W'(clamp(int'(pan_pos) + step_of(ex), int'(PAN_MIN), int'(PAN_MAX)));
        tilt_pos = SERVO_W'(clamp(int'(tilt_pos) + step_of(ey), int'(TILT_MIN),
                                  int'(TILT_MAX)));
        r.reached = (ex * ex + ey * ey) < int'(NEAR_SQ);
        if (r.reached) track_idx = IDX_W'((int'(track_idx) + 1) % (4 * int'(path_segs)));
        r.active   = 1'b1;
        r.pan      = pan_pos;
        r.tilt     = tilt_pos;
        r.waypoint = track_idx;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic int far_offset();
        int mag;
        mag = $urandom_range(15, 80);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_fail = n_fail + 1;
        end
    endfunction

    // Spot driver: holds each request until it is taken, then waits out a random gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            spot_gap = 0;
        end else begin
            if (drv_valid && spot_bus.ready) begin
                expected_cmds.push_back(servo_step(drv_spot));
                n_taken = n_taken + 1;
            end
            if (!drv_valid || spot_bus.ready) begin
                if (spot_gap > 0) begin
                    spot_gap = spot_gap - 1;
                    drv_valid <= 1'b0;
                end else if (pending_spots.size() != 0) begin
                    drv_spot  <= pending_spots.pop_front();
                    drv_valid <= 1'b1;
                    spot_gap = pick_gap();
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Command monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mon_ready <= 1'b0;
            cmd_gap = 0;
        end else begin
            if (cmd_bus.valid && mon_ready) begin
                if (expected_cmds.size() == 0) begin
                    $error("servo command with no request pending");
                    n_fail = n_fail + 1;
                end else begin
                    oldest_cmd = expected_cmds.pop_front();
                    check_field("active", oldest_cmd.active, cmd_bus.active);
                    check_field("pan_position", oldest_cmd.pan, cmd_bus.pan_position);
                    check_field("tilt_position", oldest_cmd.tilt, cmd_bus.tilt_position);
                    check_field("pan_rate", oldest_cmd.pan_rate, cmd_bus.pan_rate);
                    check_field("tilt_rate", oldest_cmd.tilt_rate, cmd_bus.tilt_rate);
                    check_field("waypoint", oldest_cmd.waypoint, cmd_bus.waypoint);
                    check_field("reached", oldest_cmd.reached, cmd_bus.reached);
                end
            end
            if (cmd_gap > 0) begin
                cmd_gap = cmd_gap - 1;
                mon_ready <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) cmd_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (spot_bus.valid && spot_bus.ready) || (cmd_bus.valid && cmd_bus.ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("** waypoint_tracking_servo_step: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send(input logic [CW-1:0] x, input logic [CW-1:0] y);
        t_spot_pos s;
        s.x = x;
        s.y = y;
        pending_spots.push_back(s);
        n_queued = n_queued + 1;
    endtask

    // Waits until every request so far is taken, then aims relative to the live waypoint.
    task automatic aim(input int dx, input int dy);
        int tx, ty;
        while (n_taken != n_queued) @(posedge i_clk);
        if (track_target(tx, ty)) send(CW'(tx + dx), CW'(ty + dy));
        else send(CW'($urandom), CW'($urandom));
    endtask

    task automatic settle();
        while (n_taken != n_queued || expected_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CORNER_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SEGMENTS) path_segs = data[SEG_W-1:0];
        else path_corner[idx] = data;
    endtask

    // Bits above the segment field carry junk; the block must ignore them.
    task automatic set_segments(input int seg);
        settle();
        write_reg(CFG_SEGMENTS, {(CORNER_W - SEG_W)'($urandom), SEG_W'(seg)});
    endtask

    task automatic set_path(input logic [CORNER_W-1:0] a, input logic [CORNER_W-1:0] b,
                            input logic [CORNER_W-1:0] c, input logic [CORNER_W-1:0] d,
                            input int seg);
        settle();
        write_reg(CFG_CORNER_A, a);
        write_reg(CFG_CORNER_B, b);
        write_reg(CFG_CORNER_C, c);
        write_reg(CFG_CORNER_D, d);
        set_segments(seg);
    endtask

    task automatic walk(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 75) aim(int'($urandom_range(0, 32)) - 16, int'($urandom_range(0, 32)) - 16);
            else if (r < 88) aim(far_offset(), far_offset());
            else send(CW'($urandom), CW'($urandom));
            if ($urandom_range(0, 59) == 0) settle();
        end
    endtask

    // Spots mostly beyond a fixed point on both axes: both servos keep stepping down to their floor.
    task automatic drive_off(input int n);
        repeat (n) begin
            if ($urandom_range(0, 99) < 92) send(CW'($urandom_range(230, 1023)),
                                                 CW'($urandom_range(230, 1023)));
            else send(CW'($urandom), CW'($urandom));
        end
    endtask

    initial begin
        int seg;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Nothing configured yet, so the path is invalid.
        send('0, '0);
        send('1, '1);

        set_path({10'd100, 10'd100}, {10'd120, 10'd900}, {10'd860, 10'd880},
                 {10'd900, 10'd130}, 4);
        aim(0, 0);
        aim(15, -15);
        aim(-14, 14);
        aim(22, 3);
        aim(22, 4);
        aim(300, -300);
        repeat (13) aim(0, 0);

        // Corners at the coordinate extremes, one waypoint per side.
        set_path(20'h00000, 20'h003FF, 20'hFFFFF, 20'hFFC00, 1);
        repeat (4) aim(0, 0);

        set_path(CORNER_W'($urandom), CORNER_W'($urandom), CORNER_W'($urandom),
                 CORNER_W'($urandom), $urandom_range(1, 8));
        walk(12);
        set_path(CORNER_W'($urandom), CORNER_W'($urandom), CORNER_W'($urandom),
                 CORNER_W'($urandom), SEG_MAX);
        walk(20);

        set_segments(SEG_MAX + 1);
        walk(4);
        set_segments(63);
        walk(2);
        set_segments(0);
        walk(2);

        // If the index is 4 or more, shrink the path below it: the block must stay inactive.
        settle();
        seg = (track_idx >= 4) ? $urandom_range(1, track_idx / 4) : 1;
        set_segments(seg);
        walk(4);

        no_gaps = 1'b1;
        set_path(CORNER_W'($urandom), CORNER_W'($urandom), CORNER_W'($urandom),
                 CORNER_W'($urandom), SEG_MAX);
        walk(10);

        no_gaps = 1'b0;
        set_path({10'd200, 10'd200}, {10'd200, 10'd200}, {10'd200, 10'd200},
                 {10'd200, 10'd200}, SEG_MAX);
        drive_off(160);
        settle();
        no_gaps = 1'b1;
        drive_off(160);
        settle();
        no_gaps = 1'b0;

        settle();
        repeat (60) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("** waypoint_tracking_servo_step: PASSED **");
        end else begin
            $display("** waypoint_tracking_servo_step: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
